/* hw/rtl/bdgu_pkg.sv */
// ============================================================================
// bdgu_pkg: shared types and constants of the branching graph updater
// Field widths, reset node count, item mode and status codes and the sequencer state type.
// ============================================================================
package bdgu_pkg;

    // Field widths fixed by the item format
    localparam int MODE_W = 3;
    localparam int IDX_W  = 6;
    localparam int ROW_W  = 64;
    localparam int CNT_W  = 7;

    // Node count after reset
    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SAME   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DIFFER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MERGE  = 3'd4;

    // Result status codes
    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_RD_FIRST,
        S_RD_SECOND,
        S_EVAL,
        S_SWEEP,
        S_MERGE_FIRST,
        S_MERGE_SECOND,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/branch_decision_graph_update.sv */
// ============================================================================
// branch_decision_graph_update: branching decision update of a dense graph
// Adjacency rows and class member masks held in single-port-read memories,
// updated by a read-modify-write sweep over the rows.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one item: load row, read
//   row, SAME, DIFFER or merge-only. Output channel (o_out_valid /
//   i_out_ready) returns exactly one result item per input item.
//   The node count register is written through i_cfg_we / i_cfg_wdata; the
//   user writes it only while the block is idle, which the block itself
//   does not enforce. SAME and DIFFER run a row sweep: one read-modify-write
//   of an adjacency row per cycle over all NODES rows. One item is in work
//   at a time; input ready rises again in the same cycle as the result is
//   registered.
//   The output register holds a result while the receiver stalls; the block
//   still takes the next item, and waits before delivering its result.
//   Reset: node count 64, every node its own class, no result pending.
//   Adjacency rows hold nothing defined until loaded.
// ============================================================================
module branch_decision_graph_update #(
    parameter int NODES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_mode,
    input  logic [5:0]  i_first_node,
    input  logic [5:0]  i_second_node,
    input  logic [63:0] i_row_in,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_row_index,
    output logic [63:0] o_row_out,
    output logic        o_status
);

    localparam int IW = $clog2(NODES);
    localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);
    localparam logic [bdgu_pkg::CNT_W-1:0] NODES_CNT = bdgu_pkg::CNT_W'(NODES);

    // Control state
    bdgu_pkg::t_state r_state, n_state;
    logic [bdgu_pkg::CNT_W-1:0] r_cfg_count;
    logic [NODES-1:0] r_is_rep, n_is_rep;
    logic [NODES-1:0] r_mem_vld, n_mem_vld;
    logic r_out_vld;
    logic out_load;

    // Item payload and working registers
    logic [bdgu_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [bdgu_pkg::IDX_W-1:0]  r_f, n_f, r_s, n_s;
    logic [bdgu_pkg::ROW_W-1:0]  r_mf, n_mf, r_ms, n_ms;
    logic [bdgu_pkg::ROW_W-1:0]  r_adj_f, n_adj_f, r_adj_s, n_adj_s;
    logic [bdgu_pkg::ROW_W-1:0]  r_add_f, n_add_f, r_add_s, n_add_s;
    logic [IW-1:0]               r_idx, n_idx;
    logic [bdgu_pkg::ROW_W-1:0]  r_res_row, n_res_row;
    logic                        r_res_status, n_res_status;
    logic [bdgu_pkg::IDX_W-1:0]  r_out_index;
    logic [bdgu_pkg::ROW_W-1:0]  r_out_row;
    logic                        r_out_status;

    // Adjacency memory
    logic [bdgu_pkg::ROW_W-1:0] r_adj_mem [NODES];
    logic [bdgu_pkg::ROW_W-1:0] r_adj_rd;
    logic                       adj_we;
    logic [IW-1:0]              adj_waddr, adj_raddr;
    logic [bdgu_pkg::ROW_W-1:0] adj_wdata;

    // Class member memory
    logic [bdgu_pkg::ROW_W-1:0] r_mem_mem [NODES];
    logic [bdgu_pkg::ROW_W-1:0] r_mem_rd;
    logic                       r_mem_rd_vld;
    logic [IW-1:0]              r_mem_rd_addr;
    logic                       mem_we;
    logic [IW-1:0]              mem_waddr, mem_raddr;
    logic [bdgu_pkg::ROW_W-1:0] mem_wdata;
    logic [bdgu_pkg::ROW_W-1:0] mem_rd_eff;

    // Decode helpers
    logic                        in_accept;
    logic [bdgu_pkg::CNT_W-1:0]  eff_count;
    logic [bdgu_pkg::ROW_W-1:0]  keep_mask;
    logic                        f_ok, s_ok, decision_ok;
    logic [bdgu_pkg::ROW_W-1:0]  sweep_or;

    assign o_in_ready = (r_state == bdgu_pkg::S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;

    // Effective node count: zero acts as one, clamp at NODES
    always_comb begin
        if (r_cfg_count == '0) begin
            eff_count = bdgu_pkg::CNT_W'(1);
        end else if (r_cfg_count > NODES_CNT) begin
            eff_count = NODES_CNT;
        end else begin
            eff_count = r_cfg_count;
        end
    end

    // Bits of a loaded row that lie inside the node count
    always_comb begin
        for (int i = 0; i < bdgu_pkg::ROW_W; i++) begin
            keep_mask[i] = (bdgu_pkg::CNT_W'(i) < eff_count);
        end
    end

    // Precondition checks on the incoming item
    assign f_ok = ({1'b0, i_first_node} < eff_count);
    assign s_ok = ({1'b0, i_second_node} < eff_count);
    assign decision_ok = f_ok && s_ok && (i_first_node != i_second_node)
                         && r_is_rep[i_first_node[IW-1:0]]
                         && r_is_rep[i_second_node[IW-1:0]];

    // Never-written member entry reads as its own one-hot bit
    assign mem_rd_eff = r_mem_rd_vld ? r_mem_rd
                                     : (bdgu_pkg::ROW_W'(1) << r_mem_rd_addr);

    // Bits ORed into the row under the sweep: class rows and symmetric columns
    assign sweep_or = (r_mf[r_idx] ? r_add_f : '0) | (r_ms[r_idx] ? r_add_s : '0)
                    | (r_add_f[r_idx] ? r_mf : '0) | (r_add_s[r_idx] ? r_ms : '0);

    // Sequencer: next state, memory controls and working registers
    always_comb begin
        n_state      = r_state;
        n_is_rep     = r_is_rep;
        n_mem_vld    = r_mem_vld;
        n_mode       = r_mode;
        n_f          = r_f;
        n_s          = r_s;
        n_mf         = r_mf;
        n_ms         = r_ms;
        n_adj_f      = r_adj_f;
        n_adj_s      = r_adj_s;
        n_add_f      = r_add_f;
        n_add_s      = r_add_s;
        n_idx        = r_idx;
        n_res_row    = r_res_row;
        n_res_status = r_res_status;
        out_load     = 1'b0;
        adj_we       = 1'b0;
        adj_waddr    = r_idx;
        adj_wdata    = r_adj_rd | sweep_or;
        adj_raddr    = r_idx;
        mem_we       = 1'b0;
        mem_waddr    = r_f[IW-1:0];
        mem_wdata    = r_mf | r_ms;
        mem_raddr    = r_f[IW-1:0];

        unique case (r_state)
            bdgu_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_mode       = i_mode;
                    n_f          = i_first_node;
                    n_s          = i_second_node;
                    n_res_row    = '0;
                    n_res_status = bdgu_pkg::STATUS_DONE;
                    n_state      = bdgu_pkg::S_DONE;
                    unique case (i_mode) inside
                        bdgu_pkg::MODE_LOAD: begin
                            if (!f_ok) begin
                                n_res_status = bdgu_pkg::STATUS_REJECTED;
                            end else begin
                                adj_we    = 1'b1;
                                adj_waddr = i_first_node[IW-1:0];
                                adj_wdata = i_row_in & keep_mask;
                            end
                        end
                        bdgu_pkg::MODE_READ: begin
                            if (!f_ok) begin
                                n_res_status = bdgu_pkg::STATUS_REJECTED;
                            end else begin
                                adj_raddr = i_first_node[IW-1:0];
                                n_state   = bdgu_pkg::S_READ;
                            end
                        end
                        bdgu_pkg::MODE_SAME, bdgu_pkg::MODE_DIFFER,
                        bdgu_pkg::MODE_MERGE: begin
                            if (!decision_ok) begin
                                n_res_status = bdgu_pkg::STATUS_REJECTED;
                            end else begin
                                adj_raddr = i_first_node[IW-1:0];
                                mem_raddr = i_first_node[IW-1:0];
                                n_state   = bdgu_pkg::S_RD_FIRST;
                            end
                        end
                        default: begin
                            n_res_status = bdgu_pkg::STATUS_REJECTED;
                        end
                    endcase
                end
            end
            bdgu_pkg::S_READ: begin
                n_res_row = r_adj_rd;
                n_state   = bdgu_pkg::S_DONE;
            end
            bdgu_pkg::S_RD_FIRST: begin
                n_mf      = mem_rd_eff;
                n_adj_f   = r_adj_rd;
                adj_raddr = r_s[IW-1:0];
                mem_raddr = r_s[IW-1:0];
                n_state   = bdgu_pkg::S_RD_SECOND;
            end
            bdgu_pkg::S_RD_SECOND: begin
                n_ms    = mem_rd_eff;
                n_adj_s = r_adj_rd;
                n_state = bdgu_pkg::S_EVAL;
            end
            bdgu_pkg::S_EVAL: begin
                // Edge present in either direction rejects SAME and DIFFER
                if ((r_mode != bdgu_pkg::MODE_MERGE) && (r_adj_f[r_s] || r_adj_s[r_f])) begin
                    n_res_status = bdgu_pkg::STATUS_REJECTED;
                    n_state      = bdgu_pkg::S_DONE;
                end else if (r_mode == bdgu_pkg::MODE_MERGE) begin
                    n_state = bdgu_pkg::S_MERGE_FIRST;
                end else begin
                    if (r_mode == bdgu_pkg::MODE_SAME) begin
                        n_add_f = r_adj_s & ~r_adj_f;
                        n_add_s = r_adj_f & ~r_adj_s;
                    end else begin
                        n_add_f = r_ms;
                        n_add_s = r_mf;
                    end
                    n_idx     = '0;
                    adj_raddr = '0;
                    n_state   = bdgu_pkg::S_SWEEP;
                end
            end
            bdgu_pkg::S_SWEEP: begin
                // Write row r_idx back while row r_idx + 1 is read
                adj_we = 1'b1;
                if (r_idx == LAST_IDX) begin
                    adj_raddr = '0;
                    n_idx     = '0;
                    n_state   = (r_mode == bdgu_pkg::MODE_SAME) ? bdgu_pkg::S_MERGE_FIRST
                                                                : bdgu_pkg::S_DONE;
                end else begin
                    adj_raddr = r_idx + 1'b1;
                    n_idx     = r_idx + 1'b1;
                end
            end
            bdgu_pkg::S_MERGE_FIRST: begin
                mem_we                 = 1'b1;
                mem_waddr              = r_f[IW-1:0];
                mem_wdata              = r_mf | r_ms;
                n_mem_vld[r_f[IW-1:0]] = 1'b1;
                n_state                = bdgu_pkg::S_MERGE_SECOND;
            end
            bdgu_pkg::S_MERGE_SECOND: begin
                mem_we                 = 1'b1;
                mem_waddr              = r_s[IW-1:0];
                mem_wdata              = '0;
                n_mem_vld[r_s[IW-1:0]] = 1'b1;
                n_is_rep[r_s[IW-1:0]]  = 1'b0;
                n_state                = bdgu_pkg::S_DONE;
            end
            bdgu_pkg::S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = bdgu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bdgu_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdgu_pkg::S_IDLE;
            r_cfg_count <= bdgu_pkg::NODE_COUNT_RESET;
            r_is_rep    <= '1;
            r_mem_vld   <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_rep  <= n_is_rep;
            r_mem_vld <= n_mem_vld;
            if (i_cfg_we) begin
                r_cfg_count <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_f          <= n_f;
        r_s          <= n_s;
        r_mf         <= n_mf;
        r_ms         <= n_ms;
        r_adj_f      <= n_adj_f;
        r_adj_s      <= n_adj_s;
        r_add_f      <= n_add_f;
        r_add_s      <= n_add_s;
        r_idx        <= n_idx;
        r_res_row    <= n_res_row;
        r_res_status <= n_res_status;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_index  <= r_f;
            r_out_row    <= r_res_row;
            r_out_status <= r_res_status;
        end
    end

    // Adjacency memory, registered read
    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            r_adj_mem[adj_waddr] <= adj_wdata;
        end
        r_adj_rd <= r_adj_mem[adj_raddr];
    end

    // Class member memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_rd      <= r_mem_mem[mem_raddr];
        r_mem_rd_vld  <= r_mem_vld[mem_raddr];
        r_mem_rd_addr <= mem_raddr;
    end

    assign o_out_valid = r_out_vld;
    assign o_row_index = r_out_index;
    assign o_row_out   = r_out_row;
    assign o_status    = r_out_status;

endmodule

/* hw/rtl/bdgu_checker.sv */
// ============================================================================
// bdgu_checker: port-level checks of the branching graph updater
// Watches the configuration, input and output channels of the top level.
// ============================================================================
module bdgu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [2:0]  i_mode,
    input logic [5:0]  i_first_node,
    input logic [5:0]  i_second_node,
    input logic [63:0] i_row_in,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  o_row_index,
    input logic [63:0] o_row_out,
    input logic        o_status
);

    // One item in work at a time: ready drops after an accept
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready stayed high after an accepted item");

    // Waiting input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_mode)
            && $stable(i_first_node) && $stable(i_second_node) && $stable(i_row_in)))
        else $error("waiting input item changed or vanished");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_row_index)
            && $stable(o_row_out) && $stable(o_status)))
        else $error("stalled result item changed or vanished");

    // Rejected items return an empty row
    a_reject_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == bdgu_pkg::STATUS_REJECTED))
            |-> (o_row_out == {bdgu_pkg::ROW_W{1'b0}}))
        else $error("rejected result item carries row bits");

    // Node count changes only with nothing in work
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> (o_in_ready && !o_out_valid))
        else $error("node count written while an item was in work");

endmodule

bind branch_decision_graph_update bdgu_checker u_bdgu_checker (.*);
